// File: hw/rtl/sha_pkg.sv
`default_nettype none

package sha_pkg;

   localparam int BLOCK_W = 512;

   localparam logic [5:0] FILL_LAST = 6'd63;
   localparam logic [5:0] LEN_POS = 6'd56;
   localparam logic [5:0] ROUND_LAST = 6'd63;
   localparam logic [2:0] WORD_LAST = 3'd7;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [63:0] BITS_PER_BYTE = 64'd8;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0][31:0] INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   typedef enum logic [1:0] {
      SRC_MSG,
      SRC_PAD,
      SRC_ZERO,
      SRC_LEN
   } sha_src_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD80,
      ST_ZERO,
      ST_LEN,
      ST_EMIT
   } sha_state_type;

   typedef struct packed {
      logic        shift_en;
      sha_src_type src;
      logic [2:0]  len_sel;
      logic        count_bits;
      logic        round_en;
      logic [5:0]  round_idx;
      logic        fold;
      logic        restart;
      logic [2:0]  word_sel;
   } sha_cmd_type;

   typedef struct packed {
      logic [5:0] fill;
   } sha_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/sha256_hasher_core.sv
// Streaming SHA-256 engine. Each req transaction carries at most one message byte and an
// end-of-message flag; a transaction with no byte and the flag set closes the message as it
// stands. While idle the engine accepts one byte per cycle. Every 64th byte starts the
// compression, which runs one round per cycle through a single round unit: 64 rounds and a
// fold step, during which req_ready is low. At end of message the engine shifts in the 0x80
// pad byte, zero fill and the 64-bit big-endian bit length (up to 72 bytes) and runs one or
// two more compressions. It then presents the eight digest words, index 0 most significant,
// as eight rsp transactions, and re-initializes for the next message.
`default_nettype none

module sha256_hasher_core
   import sha_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_has_byte,
   input  wire logic [7:0]  req_message_byte,
   input  wire logic        req_end_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);

   sha_cmd_type    cmd;
   sha_status_type sts;

   sha_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_has_byte       (req_has_byte),
      .req_end_of_message (req_end_of_message),
      .req_ready          (req_ready),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word),
      .sts                (sts),
      .cmd                (cmd)
   );

   sha_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .msg_byte    (req_message_byte),
      .cmd         (cmd),
      .sts         (sts),
      .digest_word (rsp_digest_word)
   );

endmodule

`default_nettype wire

// File: hw/rtl/sha_dp.sv
`default_nettype none

module sha_dp
   import sha_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [7:0]     msg_byte,
   input  wire sha_cmd_type    cmd,
   output sha_status_type      sts,
   output logic [31:0]         digest_word
);

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   logic [BLOCK_W-1:0]  win_ff, win_in;
   logic [7:0][31:0]    wv_ff, wv_in;
   logic [7:0][31:0]    chain_ff, chain_in;
   logic [5:0]          fill_ff, fill_in;
   logic [63:0]         bits_ff, bits_in;

   logic [7:0]  byte_sel;
   logic [31:0] w0, w1, w9, w14, sg0, sg1, new_w;
   logic [31:0] s0, s1, ch, mj, t1, t2;
   logic        wrap;

   assign w0  = win_ff[511:480];
   assign w1  = win_ff[479:448];
   assign w9  = win_ff[223:192];
   assign w14 = win_ff[63:32];

   always_comb begin
      unique case (cmd.src)
         SRC_MSG:  byte_sel = msg_byte;
         SRC_PAD:  byte_sel = PAD_BYTE;
         SRC_ZERO: byte_sel = 8'h00;
         SRC_LEN:  byte_sel = 8'(bits_ff >> {~cmd.len_sel, 3'b000});
         default:  byte_sel = 8'h00;
      endcase
   end

   always_comb begin
      sg0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
      sg1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
      new_w = sg1 + w9 + sg0 + w0;
      s1 = rotr(wv_ff[4], 6) ^ rotr(wv_ff[4], 11) ^ rotr(wv_ff[4], 25);
      ch = (wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]);
      t1 = wv_ff[7] + s1 + ch + ROUND_K[cmd.round_idx] + w0;
      s0 = rotr(wv_ff[0], 2) ^ rotr(wv_ff[0], 13) ^ rotr(wv_ff[0], 22);
      mj = (wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]);
      t2 = s0 + mj;
   end

   assign wrap = cmd.shift_en && (fill_ff == FILL_LAST);

   always_comb begin
      win_in = win_ff;
      wv_in = wv_ff;
      chain_in = chain_ff;
      fill_in = fill_ff;
      bits_in = bits_ff;
      if (cmd.shift_en) begin
         win_in = {win_ff[BLOCK_W-9:0], byte_sel};
         fill_in = fill_ff + 6'd1;
      end else if (cmd.round_en) begin
         win_in = {win_ff[BLOCK_W-33:0], new_w};
      end
      if (wrap) begin
         wv_in = chain_ff;
      end else if (cmd.round_en) begin
         wv_in[7] = wv_ff[6];
         wv_in[6] = wv_ff[5];
         wv_in[5] = wv_ff[4];
         wv_in[4] = wv_ff[3] + t1;
         wv_in[3] = wv_ff[2];
         wv_in[2] = wv_ff[1];
         wv_in[1] = wv_ff[0];
         wv_in[0] = t1 + t2;
      end
      if (cmd.count_bits) begin
         bits_in = bits_ff + BITS_PER_BYTE;
      end
      if (cmd.fold) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + wv_ff[i];
         end
      end
      if (cmd.restart) begin
         chain_in = INIT_HASH;
         bits_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= INIT_HASH;
         fill_ff <= '0;
         bits_ff <= '0;
      end else begin
         chain_ff <= chain_in;
         fill_ff <= fill_in;
         bits_ff <= bits_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      wv_ff <= wv_in;
   end

   assign sts.fill = fill_ff;
   assign digest_word = chain_ff[cmd.word_sel];

endmodule

`default_nettype wire

// File: hw/rtl/sha_ctrl.sv
`default_nettype none

module sha_ctrl
   import sha_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_has_byte,
   input  wire logic           req_end_of_message,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output logic [2:0]          rsp_word_index,
   output logic                rsp_last_word,
   input  wire sha_status_type sts,
   output sha_cmd_type         cmd
);

   sha_state_type state_ff, state_in;
   sha_state_type ret_ff, ret_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          at_last;

   assign at_last = (sts.fill == FILL_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      cnt_in = cnt_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd.shift_en = 1'b0;
      cmd.src = SRC_MSG;
      cmd.len_sel = cnt_ff[2:0];
      cmd.count_bits = 1'b0;
      cmd.round_en = 1'b0;
      cmd.round_idx = cnt_ff;
      cmd.fold = 1'b0;
      cmd.restart = 1'b0;
      cmd.word_sel = cnt_ff[2:0];
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.shift_en = req_has_byte;
               cmd.count_bits = req_has_byte;
               if (req_has_byte && at_last) begin
                  state_in = ST_ROUND;
                  cnt_in = '0;
                  ret_in = req_end_of_message ? ST_PAD80 : ST_IDLE;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD80;
               end
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == ROUND_LAST) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            cnt_in = '0;
            state_in = ret_ff;
         end
         ST_PAD80: begin
            cmd.shift_en = 1'b1;
            cmd.src = SRC_PAD;
            state_in = ST_ZERO;
            if (at_last) begin
               state_in = ST_ROUND;
               ret_in = ST_ZERO;
               cnt_in = '0;
            end
         end
         ST_ZERO: begin
            if (sts.fill == LEN_POS) begin
               state_in = ST_LEN;
               cnt_in = '0;
            end else begin
               cmd.shift_en = 1'b1;
               cmd.src = SRC_ZERO;
               if (at_last) begin
                  state_in = ST_ROUND;
                  ret_in = ST_ZERO;
                  cnt_in = '0;
               end
            end
         end
         ST_LEN: begin
            cmd.shift_en = 1'b1;
            cmd.src = SRC_LEN;
            cnt_in = cnt_ff + 6'd1;
            if (at_last) begin
               state_in = ST_ROUND;
               ret_in = ST_EMIT;
               cnt_in = '0;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff[2:0] == WORD_LAST) begin
                  cmd.restart = 1'b1;
                  cnt_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_word_index = cnt_ff[2:0];
   assign rsp_last_word = (cnt_ff[2:0] == WORD_LAST);

endmodule

`default_nettype wire
